// File: design/dtpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: shared package
// Field widths, register indexes and reset values, the command and status
// structs between controller and datapath, and the rounding helpers.
// ----------------------------------------------------------------------------
package dtpc_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = 3'd6;

  // Field widths
  localparam int SIZE_W   = 13;
  localparam int DEPTH_W  = 16;
  localparam int SCALE_W  = 16;
  localparam int CENTER_W = 20;
  localparam int INV_W    = 24;
  localparam int Z_W      = 20;
  localparam int COORD_W  = 32;

  // Register reset values
  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH  = 13'd192;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT = 13'd108;
  localparam logic [CENTER_W-1:0] RST_CENTER_X     = 20'd24395;
  localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 20'd13569;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 24'd88046;
  localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 24'd88046;
  localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE  = 16'd4096;

  // Datapath widths
  localparam int POS_W  = 16;              // pixel position, integer part
  localparam int FRAC_W = 8;               // fraction bits of the centre
  localparam int MAG_W  = POS_W + FRAC_W;  // |u - cx| in Q.8
  localparam int DU_W   = MAG_W + 1;
  localparam int MUL_W  = 24;              // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int M_W    = MAG_W + Z_W;     // |du| * z
  localparam int HALF_W = M_W / 2;
  localparam int ACC_W  = HALF_W + INV_W;  // one partial product
  localparam int SUM_W  = ACC_W + HALF_W;  // full product of m and 1/f
  localparam int SHIFT  = 24;              // Q0.24 reciprocal
  localparam int R_W    = SUM_W - SHIFT;
  localparam int ZSUM_W = DEPTH_W + SCALE_W + 1;
  localparam int ZFRAC  = 12;              // Q4.12 depth scale

  localparam logic [SUM_W-1:0]  ROUND_HALF = SUM_W'(1) << (SHIFT - 1);
  localparam logic [ZSUM_W-1:0] Z_HALF     = ZSUM_W'(1) << (ZFRAC - 1);

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [SCALE_W-1:0]  depth_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_Z,    // depth times depth scale
    MUL_MAG,  // |du| times z
    MUL_LO,   // low half of m times reciprocal focal length
    MUL_HI    // high half of m times reciprocal focal length
  } mul_op_t;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } axis_t;

  typedef struct packed {
    logic    take;       // transaction on the input channel
    logic    mul_en;
    mul_op_t mul_op;
    axis_t   axis;
    logic    z_load;
    logic    m_load;
    logic    acc_load;
    logic    x_load;
    logic    out_point;
    logic    out_fend;
  } dp_cmd_t;

  typedef struct packed {
    logic in_depth_zero;
    logic in_frame_end;
    logic out_free;
  } dp_stat_t;

  // Rounded product to depth units with saturation, sign applied last.
  function automatic logic [COORD_W-1:0] round_sat(input logic neg,
                                                   input logic [SUM_W-1:0] sum);
    logic [R_W-1:0] r;
    r = sum[SUM_W-1:SHIFT];
    if (neg) begin
      if (r >= R_W'(33'h0_8000_0000)) return 32'h8000_0000;
      return 32'h0 - r[COORD_W-1:0];
    end
    if (r > R_W'(33'h0_7FFF_FFFF)) return 32'h7FFF_FFFF;
    return r[COORD_W-1:0];
  endfunction

  // Scaled depth, rounded to depth units and saturated to the z width.
  function automatic logic [Z_W-1:0] round_z(input logic [PROD_W-1:0] p);
    logic [ZSUM_W-1:0] s;
    s = ZSUM_W'(p[DEPTH_W+SCALE_W-1:0]) + Z_HALF;
    if (s[ZSUM_W-1:ZFRAC] > (ZSUM_W-ZFRAC)'({Z_W{1'b1}})) return '1;
    return s[ZFRAC+Z_W-1:ZFRAC];
  endfunction

endpackage

// File: design/dtpc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: configuration registers
// Holds the seven camera registers and gives the image size clamped to the
// supported range.
// ----------------------------------------------------------------------------
module dtpc_cfg
  import dtpc_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WS_W = $clog2(MAX_WIDTH + 1),
  localparam int HS_W = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic [WS_W-1:0]       width_eff,
  output logic [HS_W-1:0]       height_eff
);

  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RST_IMAGE_WIDTH;
      image_height    <= RST_IMAGE_HEIGHT;
      cfg.center_x    <= RST_CENTER_X;
      cfg.center_y    <= RST_CENTER_Y;
      cfg.inv_focal_x <= RST_INV_FOCAL_X;
      cfg.inv_focal_y <= RST_INV_FOCAL_Y;
      cfg.depth_scale <= RST_DEPTH_SCALE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width     <= cfg_data[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: image_height    <= cfg_data[SIZE_W-1:0];
        REG_CENTER_X:     cfg.center_x    <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     cfg.center_y    <= cfg_data[CENTER_W-1:0];
        REG_INV_FOCAL_X:  cfg.inv_focal_x <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y:  cfg.inv_focal_y <= cfg_data[INV_W-1:0];
        REG_DEPTH_SCALE:  cfg.depth_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero counts as one; a size above the maximum counts as the maximum.
  always_comb begin
    if (image_width == '0) begin
      width_eff = WS_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      width_eff = WS_W'(MAX_WIDTH);
    end else begin
      width_eff = WS_W'(image_width);
    end
    if (image_height == '0) begin
      height_eff = HS_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      height_eff = HS_W'(MAX_HEIGHT);
    end else begin
      height_eff = HS_W'(image_height);
    end
  end

endmodule

// File: design/dtpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: datapath
// Position counters, the shared 24 x 24 multiplier with its working registers,
// rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module dtpc_datapath
  import dtpc_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  localparam int WS_W = $clog2(MAX_WIDTH + 1),
  localparam int HS_W = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic [WS_W-1:0]           width_eff,
  input  logic [HS_W-1:0]           height_eff,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  input  logic [DEPTH_W-1:0]        depth,
  input  logic                      frame_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic [Z_W-1:0]            point_z,
  output logic                      point_valid,
  output logic                      frame_end
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);

  logic [CW-1:0]      column_count;
  logic [RW-1:0]      row_count;
  logic [CW-1:0]      u_cur;
  logic [RW-1:0]      v_cur;
  logic               last_col;
  logic               last_row;
  logic [CW-1:0]      column_next;
  logic [RW-1:0]      row_next;

  logic [MAG_W-1:0]   mag_u;
  logic [MAG_W-1:0]   mag_v;
  logic               neg_u;
  logic               neg_v;
  logic [DU_W-1:0]    du;
  logic [DU_W-1:0]    dv;

  logic [MAG_W-1:0]   mag_x;
  logic [MAG_W-1:0]   mag_y;
  logic               neg_x;
  logic               neg_y;
  logic               fend_hold;
  logic [Z_W-1:0]     z;
  logic [M_W-1:0]     m;
  logic [ACC_W-1:0]   acc;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] x_res;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_out;
  logic [INV_W-1:0]   inv_sel;
  logic [SUM_W-1:0]   sum;
  logic [COORD_W-1:0] coord;

  // Pixel position; a frame start puts the pixel at the origin.
  assign u_cur    = frame_start ? '0 : column_count;
  assign v_cur    = frame_start ? '0 : row_count;
  assign last_col = ({1'b0, u_cur} + (CW+1)'(1)) >= (CW+1)'(width_eff);
  assign last_row = ({1'b0, v_cur} + (RW+1)'(1)) >= (RW+1)'(height_eff);

  always_comb begin
    column_next = last_col ? '0 : u_cur + CW'(1);
    if (last_col) begin
      row_next = last_row ? '0 : v_cur + RW'(1);
    end else begin
      row_next = v_cur;
    end
  end

  // Signed offset from the principal point in Q.8, kept as sign and magnitude.
  assign du    = {1'b0, POS_W'(u_cur), FRAC_W'(0)} - DU_W'(cfg.center_x);
  assign dv    = {1'b0, POS_W'(v_cur), FRAC_W'(0)} - DU_W'(cfg.center_y);
  assign neg_u = du[DU_W-1];
  assign neg_v = dv[DU_W-1];
  assign mag_u = neg_u ? MAG_W'(DU_W'(0) - du) : du[MAG_W-1:0];
  assign mag_v = neg_v ? MAG_W'(DU_W'(0) - dv) : dv[MAG_W-1:0];

  assign stat.in_depth_zero = (depth == '0);
  assign stat.in_frame_end  = last_col && last_row;
  assign stat.out_free      = !out_valid || !out_stall;

  // Shared multiplier operand selection.
  assign inv_sel = (cmd.axis == AXIS_Y) ? cfg.inv_focal_y : cfg.inv_focal_x;

  always_comb begin
    unique case (cmd.mul_op)
      MUL_Z: begin
        mul_a = MUL_W'(depth);
        mul_b = MUL_W'(cfg.depth_scale);
      end
      MUL_MAG: begin
        mul_a = (cmd.axis == AXIS_Y) ? mag_y : mag_x;
        mul_b = MUL_W'(z);
      end
      MUL_LO: begin
        mul_a = MUL_W'(prod[HALF_W-1:0]);
        mul_b = inv_sel;
      end
      MUL_HI: begin
        mul_a = MUL_W'(m[M_W-1:HALF_W]);
        mul_b = inv_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  // Low partial product in acc, high partial product in prod. The x result is
  // finished while the multiplier already works on y, so its sign follows
  // the x load rather than the axis select.
  assign sum   = SUM_W'(acc) + {prod[ACC_W-1:0], HALF_W'(0)} + ROUND_HALF;
  assign coord = round_sat(cmd.x_load ? neg_x : neg_y, sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.take) begin
        column_count <= column_next;
        row_count    <= row_next;
      end
      if (cmd.out_point || cmd.out_fend) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mag_x     <= mag_u;
      mag_y     <= mag_v;
      neg_x     <= neg_u;
      neg_y     <= neg_v;
      fend_hold <= last_col && last_row;
    end
    if (cmd.mul_en) begin
      prod <= mul_out;
    end
    if (cmd.z_load) begin
      z <= round_z(prod);
    end
    if (cmd.m_load) begin
      m <= prod[M_W-1:0];
    end
    if (cmd.acc_load) begin
      acc <= prod[ACC_W-1:0];
    end
    if (cmd.x_load) begin
      x_res <= coord;
    end
    if (cmd.out_point) begin
      point_x     <= x_res;
      point_y     <= coord;
      point_z     <= z;
      point_valid <= 1'b1;
      frame_end   <= fend_hold;
    end else if (cmd.out_fend) begin
      point_x     <= '0;
      point_y     <= '0;
      point_z     <= '0;
      point_valid <= 1'b0;
      frame_end   <= 1'b1;
    end
  end

endmodule

// File: design/dtpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud: controller
// Sequences the seven products of one point through the shared multiplier
// and hands finished results to the output register.
// ----------------------------------------------------------------------------
module dtpc_ctrl
  import dtpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ZSAT,
    S_MULX,
    S_XLO,
    S_XHI,
    S_XFIN,
    S_YLO,
    S_YHI,
    S_YFIN,
    S_FEND
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          cmd.mul_en = 1'b1;
          cmd.mul_op = MUL_Z;
          if (!stat.in_depth_zero) begin
            state_next = S_ZSAT;
          end else if (stat.in_frame_end) begin
            state_next = S_FEND;
          end
        end
      end
      S_ZSAT: begin
        cmd.z_load = 1'b1;
        state_next = S_MULX;
      end
      S_MULX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_MAG;
        cmd.axis   = AXIS_X;
        state_next = S_XLO;
      end
      S_XLO: begin
        cmd.m_load = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LO;
        cmd.axis   = AXIS_X;
        state_next = S_XHI;
      end
      S_XHI: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_HI;
        cmd.axis     = AXIS_X;
        state_next   = S_XFIN;
      end
      S_XFIN: begin
        // x is finished while |dv| * z starts.
        cmd.x_load = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_MAG;
        cmd.axis   = AXIS_Y;
        state_next = S_YLO;
      end
      S_YLO: begin
        cmd.m_load = 1'b1;
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_LO;
        cmd.axis   = AXIS_Y;
        state_next = S_YHI;
      end
      S_YHI: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_op   = MUL_HI;
        cmd.axis     = AXIS_Y;
        state_next   = S_YFIN;
      end
      S_YFIN: begin
        cmd.axis = AXIS_Y;
        if (stat.out_free) begin
          cmd.out_point = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_FEND: begin
        if (stat.out_free) begin
          cmd.out_fend = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next != S_IDLE);
    end
  end

endmodule

// File: design/depth_to_point_cloud_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth to point cloud unit
// Back-projects a raster stream of depth pixels through a pinhole camera
// model into 3-D points, with a frame-end marker on the last pixel.
// ----------------------------------------------------------------------------
// The unit takes one depth pixel per input transaction and tracks its column
// and row itself; frame_start puts the pixel at the origin. A pixel whose depth
// is zero and which does not close a frame gives nothing. The last pixel of a
// frame with zero depth gives a frame-end transaction with zero coordinates
// from state S_FEND once the output register is free, and then the next pixel
// can be taken. A pixel with nonzero depth passes through the states S_ZSAT,
// S_MULX, S_XLO, S_XHI, S_XFIN, S_YLO, S_YHI and S_YFIN before its point is
// loaded into the output register: a single 24 x 24 multiplier forms the
// scaled depth and, for each axis, the offset times z and the two halves of
// that product times the reciprocal focal length, and the input is held
// stalled meanwhile. The finished result sits in an output register, so the
// next pixel is taken while it waits to be collected; if the output side
// stalls, the following point waits in its last step. The image size
// registers are clamped to one at the bottom and to MAX_WIDTH and MAX_HEIGHT
// at the top. Coordinates are rounded half away from zero and saturated; z is
// rounded and saturated to 20 bits. Configuration is to be written by the user
// only while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module depth_to_point_cloud_unit
  import dtpc_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration writes
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  // Pixel input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [DEPTH_W-1:0]        depth,
  input  logic                      frame_start,
  // Point output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic [Z_W-1:0]            point_z,
  output logic                      point_valid,
  output logic                      frame_end
);

  localparam int WS_W = $clog2(MAX_WIDTH + 1);
  localparam int HS_W = $clog2(MAX_HEIGHT + 1);

  cfg_t            cfg;
  logic [WS_W-1:0] width_eff;
  logic [HS_W-1:0] height_eff;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  // Register file with size clamping.
  dtpc_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  // Sequencer: issues the multiplier steps in turn and owns the input stall.
  dtpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Counters, arithmetic and the output register.
  dtpc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .cmd         (cmd),
    .stat        (stat),
    .depth       (depth),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .point_valid (point_valid),
    .frame_end   (frame_end)
  );

  // A pixel with nonzero depth always occupies the multiplier afterwards.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && depth != '0 |=> in_stall)
    else $error("nonzero depth accepted without starting the computation");

  // A result without a point is a frame-end marker with zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |->
      frame_end && point_x == '0 && point_y == '0 && point_z == '0)
    else $error("frame-end transaction carries stray coordinates");

  // A point with zero depth after scaling lies at the origin.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && point_valid && point_z == '0 |-> point_x == '0 && point_y == '0)
    else $error("point with zero z has nonzero lateral coordinates");

  // Results are only loaded from a finishing step, never while idle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pixel in progress");

endmodule
